// ----- hdl/epf_pkg.sv -----
// Shared types, constants and byte-select helpers for the Ethernet/IPv4 port filter.
`timescale 1ns / 1ps
`default_nettype none

package epf_pkg;

    localparam int unsigned POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    localparam logic [7:0]  IHL_MASK       = 8'h0F;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Header byte offsets
    localparam logic [POS_W-1:0] POS_MAC_DST_LAST = 7'd5;
    localparam logic [POS_W-1:0] POS_MAC_SRC      = 7'd6;
    localparam logic [POS_W-1:0] POS_MAC_SRC_LAST = 7'd11;
    localparam logic [POS_W-1:0] POS_ETYPE_LAST   = 7'd13;
    localparam logic [POS_W-1:0] POS_VER_IHL      = 7'd14;
    localparam logic [POS_W-1:0] POS_PROTO        = 7'd23;
    localparam logic [POS_W-1:0] POS_IP_SRC       = 7'd26;
    localparam logic [POS_W-1:0] POS_IP_SRC_LAST  = 7'd29;
    localparam logic [POS_W-1:0] POS_IP_DST       = 7'd30;
    localparam logic [POS_W-1:0] POS_IP_DST_LAST  = 7'd33;

    // Verdict codes
    localparam logic [2:0] VERDICT_PASS     = 3'd0;
    localparam logic [2:0] VERDICT_DISCARD  = 3'd1;
    localparam logic [2:0] VERDICT_MAC_MISS = 3'd2;
    localparam logic [2:0] VERDICT_IP_MISS  = 3'd3;
    localparam logic [2:0] VERDICT_PORT_MISS = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_MAC_SRC  = 3'd0;
    localparam logic [2:0] REG_MAC_DST  = 3'd1;
    localparam logic [2:0] REG_IP_SRC   = 3'd2;
    localparam logic [2:0] REG_IP_DST   = 3'd3;
    localparam logic [2:0] REG_PORT_SRC = 3'd4;
    localparam logic [2:0] REG_PORT_DST = 3'd5;

    typedef struct packed {
        logic [47:0] mac_src;
        logic [47:0] mac_dst;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] port_src;
        logic [15:0] port_dst;
    } cfg_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       is_tcp;
    } result_t;

    // Byte k of a 6-byte value, k = 0 most significant
    function automatic logic [7:0] byte6(input logic [47:0] v, input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = v[47:40];
            3'd1:    r = v[39:32];
            3'd2:    r = v[31:24];
            3'd3:    r = v[23:16];
            3'd4:    r = v[15:8];
            3'd5:    r = v[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] byte4(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] byte2(input logic [15:0] v, input logic k);
        return k ? v[7:0] : v[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/epf_hdr_check.sv -----
// Per-frame header state and byte-wise match checks, with the end-of-frame verdict.
`timescale 1ns / 1ps
`default_nettype none

module epf_hdr_check
    import epf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] frame_byte,
    input  wire logic       end_of_frame,
    input  wire cfg_t       cfg,
    output result_t         res
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic [3:0]       ihl_reg,   ihl_next;
    logic [7:0]       proto_reg, proto_next;
    logic             mac_miss_reg,  mac_miss_next;
    logic             ip_miss_reg,   ip_miss_next;
    logic             port_miss_reg, port_miss_next;
    logic             ports_done_reg, ports_done_next;

    logic             active;
    logic [POS_W-1:0] mac_src_off;
    logic [POS_W-1:0] ip_src_off;
    logic [POS_W-1:0] ip_dst_off;
    logic [3:0]       ihl_use;
    logic [POS_W-1:0] port_at;
    logic [POS_W-1:0] port_end;
    logic [POS_W-1:0] port_off;
    logic             in_ports;
    logic             known;
    logic             discard;

    assign active      = (pos_reg != POS_MAX);
    assign mac_src_off = pos_reg - POS_MAC_SRC;
    assign ip_src_off  = pos_reg - POS_IP_SRC;
    assign ip_dst_off  = pos_reg - POS_IP_DST;

    // The IHL byte itself may already fall inside the port field
    assign ihl_use  = (pos_reg == POS_VER_IHL) ? 4'(frame_byte & IHL_MASK) : ihl_reg;
    assign port_at  = POS_VER_IHL + {1'b0, ihl_use, 2'b00};
    assign port_end = port_at + 7'd3;
    assign port_off = pos_reg - port_at;
    assign in_ports = (pos_reg >= POS_VER_IHL) && (pos_reg >= port_at)
                      && (pos_reg <= port_end);

    always_comb begin
        pos_next        = pos_reg;
        etype_next      = etype_reg;
        ihl_next        = ihl_reg;
        proto_next      = proto_reg;
        mac_miss_next   = mac_miss_reg;
        ip_miss_next    = ip_miss_reg;
        port_miss_next  = port_miss_reg;
        ports_done_next = ports_done_reg;

        if (active) begin
            if (pos_reg <= POS_MAC_DST_LAST) begin
                if (cfg.mac_dst != '0 && byte6(cfg.mac_dst, pos_reg[2:0]) != frame_byte) begin
                    mac_miss_next = 1'b1;
                end
            end else if (pos_reg <= POS_MAC_SRC_LAST) begin
                if (cfg.mac_src != '0
                    && byte6(cfg.mac_src, mac_src_off[2:0]) != frame_byte) begin
                    mac_miss_next = 1'b1;
                end
            end else if (pos_reg <= POS_ETYPE_LAST) begin
                etype_next = {etype_reg[7:0], frame_byte};
            end else if (pos_reg == POS_VER_IHL) begin
                ihl_next = 4'(frame_byte & IHL_MASK);
            end else if (pos_reg == POS_PROTO) begin
                proto_next = frame_byte;
            end else if (pos_reg >= POS_IP_SRC && pos_reg <= POS_IP_SRC_LAST) begin
                if (cfg.ip_src != '0 && byte4(cfg.ip_src, ip_src_off[1:0]) != frame_byte) begin
                    ip_miss_next = 1'b1;
                end
            end else if (pos_reg >= POS_IP_DST && pos_reg <= POS_IP_DST_LAST) begin
                if (cfg.ip_dst != '0 && byte4(cfg.ip_dst, ip_dst_off[1:0]) != frame_byte) begin
                    ip_miss_next = 1'b1;
                end
            end

            if (in_ports) begin
                if (!port_off[1]) begin
                    if (cfg.port_src != '0
                        && byte2(cfg.port_src, port_off[0]) != frame_byte) begin
                        port_miss_next = 1'b1;
                    end
                end else begin
                    if (cfg.port_dst != '0
                        && byte2(cfg.port_dst, port_off[0]) != frame_byte) begin
                        port_miss_next = 1'b1;
                    end
                end
                if (port_off[1:0] == 2'd3) begin
                    ports_done_next = 1'b1;
                end
            end

            pos_next = pos_reg + 7'd1;
        end
    end

    // Verdict from the state including the current (last) byte
    assign known   = (proto_next == PROTO_TCP) || (proto_next == PROTO_UDP);
    assign discard = (etype_next != ETHERTYPE_IPV4) || !known || !ports_done_next
                     || (pos_reg < POS_IP_DST_LAST);

    always_comb begin
        res.is_tcp = 1'b0;
        if (discard) begin
            res.verdict = VERDICT_DISCARD;
        end else begin
            res.is_tcp = (proto_next == PROTO_TCP);
            if (mac_miss_next) begin
                res.verdict = VERDICT_MAC_MISS;
            end else if (ip_miss_next) begin
                res.verdict = VERDICT_IP_MISS;
            end else if (port_miss_next) begin
                res.verdict = VERDICT_PORT_MISS;
            end else begin
                res.verdict = VERDICT_PASS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_frame)) begin
            pos_reg        <= '0;
            etype_reg      <= '0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            mac_miss_reg   <= 1'b0;
            ip_miss_reg    <= 1'b0;
            port_miss_reg  <= 1'b0;
            ports_done_reg <= 1'b0;
        end else if (step) begin
            pos_reg        <= pos_next;
            etype_reg      <= etype_next;
            ihl_reg        <= ihl_next;
            proto_reg      <= proto_next;
            mac_miss_reg   <= mac_miss_next;
            ip_miss_reg    <= ip_miss_next;
            port_miss_reg  <= port_miss_next;
            ports_done_reg <= ports_done_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ethernet_ip_port_packet_filter.sv -----
// Top level of the Ethernet II / IPv4 / TCP-UDP header filter.
`timescale 1ns / 1ps
`default_nettype none

// Frame bytes enter one per transaction on the s_ stream, s_tlast marking the
// last byte; a single verdict transaction leaves on the m_ stream for each
// frame end. One byte is taken every cycle while the result side keeps up; a
// byte passes an input register and the header check before the verdict lands
// in the output register.
// Match registers are written through cfg_wr_en/cfg_index/cfg_wr_data; a value
// of zero switches that check off. Write them only between frames.

module ethernet_ip_port_packet_filter
    import epf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] frame_byte
    input  wire logic        s_tlast,    // end_of_frame

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [2:0] verdict, [3] is_tcp, [7:4] zero

    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_wr_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAC_SRC:  cfg_reg.mac_src  <= cfg_wr_data;
                REG_MAC_DST:  cfg_reg.mac_dst  <= cfg_wr_data;
                REG_IP_SRC:   cfg_reg.ip_src   <= cfg_wr_data[31:0];
                REG_IP_DST:   cfg_reg.ip_dst   <= cfg_wr_data[31:0];
                REG_PORT_SRC: cfg_reg.port_src <= cfg_wr_data[15:0];
                REG_PORT_DST: cfg_reg.port_dst <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    epf_hdr_check u_hdr_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .frame_byte   (in_byte_reg),
        .end_of_frame (in_last_reg),
        .cfg          (cfg_reg),
        .res          (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.is_tcp, out_reg.verdict};

endmodule

`default_nettype wire
